// ===== sv/cbte_pkg.sv =====
// shared types, codes and constants of the cubic b-spline trajectory evaluator
// no dependencies; used by every module of the block
`default_nettype none

package cbte_pkg;

  localparam int unsigned MaxPointsDef = 64;
  // slots that a 6 bit point index can reach
  localparam int unsigned IdxSlots     = 64;

  localparam int unsigned CoordW = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SegW   = 6;
  localparam int unsigned UW     = 17;
  localparam int unsigned AccW   = 40;
  localparam int unsigned MagW   = 48;
  localparam int unsigned PointW = 3 * CoordW;

  localparam logic [UW-1:0]   UOne    = 17'h1_0000;
  localparam logic [MagW-1:0] Lim48   = '1;
  // ceil(2^36 / 3), exact floor division by three for values below 2^34
  localparam logic [34:0]     Div3Mul = 35'h5_5555_5556;

  typedef enum logic [2:0] {
    ModeWrPos   = 3'd0,
    ModeWrRot   = 3'd1,
    ModePos     = 3'd2,
    ModeVel     = 3'd3,
    ModeAcc     = 3'd4,
    ModeRotVec  = 3'd5,
    ModeRotRate = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KindPos = 2'd0,
    KindVel = 2'd1,
    KindAcc = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CfgStart       = 2'd0,
    CfgEnd         = 2'd1,
    CfgInvInterval = 2'd2,
    CfgSegCount    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic  valid;
    logic  tab;
    kind_e kind;
  } ctl_t;

  typedef struct packed {
    logic              en;
    logic              tab;
    logic [SegW-1:0]   idx;
    logic [PointW-1:0] pt;
  } wr_t;

  function automatic int unsigned slots(int unsigned max_points);
    return (max_points < IdxSlots) ? max_points : IdxSlots;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cubic_bspline_trajectory_eval_core.sv =====
// Uniform cubic b-spline evaluator. A request (start_i while busy_o is low;
// busy_o never rises) is taken every cycle. Point writes give no result; an
// evaluation gives one result_valid_o strobe through the fixed pipeline:
// three time stages, the banked point read, seven blend stages (three horner
// multiplies) and six output scaling stages. The result cannot be held off.
// Configuration writes are always taken and belong in a quiet window with no
// request in flight.
// Depends on cbte_pkg, cbte_time, cbte_mem, cbte_blend and cbte_post.
`default_nettype none

module cubic_bspline_trajectory_eval_core #(
  parameter int unsigned MaxPoints = cbte_pkg::MaxPointsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [5:0]  point_index_i,
  input  wire logic [31:0] point_x_i,
  input  wire logic [31:0] point_y_i,
  input  wire logic [31:0] point_z_i,
  input  wire logic [31:0] query_time_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             result_valid_o,
  output logic [31:0]      value_x_o,
  output logic [31:0]      value_y_o,
  output logic [31:0]      value_z_o,
  output logic [5:0]       segment_used_o,
  output logic             saturated_o
);

  logic [31:0] start_q, end_q, inv_q;
  logic [5:0]  cnt_q;

  cbte_pkg::ctl_t t_ctl, m_ctl, b_ctl;
  cbte_pkg::wr_t  t_wr;
  logic [5:0]     t_seg, m_seg, b_seg;
  logic [16:0]    t_u, m_u;
  logic [95:0]    rd [4];
  logic [3:0]     rd_vld;
  logic signed [cbte_pkg::AccW-1:0] acc [3];
  logic [31:0]    value [3];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
      inv_q   <= 32'h0001_0000;
      cnt_q   <= 6'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cbte_pkg::cfg_idx_e'(cfg_index_i))
        cbte_pkg::CfgStart:       start_q <= cfg_data_i;
        cbte_pkg::CfgEnd:         end_q   <= cfg_data_i;
        cbte_pkg::CfgInvInterval: inv_q   <= cfg_data_i;
        cbte_pkg::CfgSegCount:    cnt_q   <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  cbte_time #(.MaxPoints(MaxPoints)) u_time (
    .clk_i, .rst_ni,
    .req_i          (start_i && !busy_o),
    .mode_i,
    .point_index_i,
    .point_i        ({point_z_i, point_y_i, point_x_i}),
    .query_time_i,
    .start_time_i   (start_q),
    .end_time_i     (end_q),
    .inv_interval_i (inv_q),
    .seg_count_i    (cnt_q),
    .ctl_o          (t_ctl),
    .wr_o           (t_wr),
    .seg_o          (t_seg),
    .u_o            (t_u)
  );

  cbte_mem #(.MaxPoints(MaxPoints)) u_mem (
    .clk_i, .rst_ni,
    .ctl_i    (t_ctl),
    .wr_i     (t_wr),
    .seg_i    (t_seg),
    .u_i      (t_u),
    .ctl_o    (m_ctl),
    .seg_o    (m_seg),
    .u_o      (m_u),
    .rd_o     (rd),
    .rd_vld_o (rd_vld)
  );

  cbte_blend u_blend (
    .clk_i, .rst_ni,
    .ctl_i    (m_ctl),
    .seg_i    (m_seg),
    .u_i      (m_u),
    .rd_i     (rd),
    .rd_vld_i (rd_vld),
    .ctl_o    (b_ctl),
    .seg_o    (b_seg),
    .acc_o    (acc)
  );

  cbte_post u_post (
    .clk_i, .rst_ni,
    .ctl_i   (b_ctl),
    .seg_i   (b_seg),
    .acc_i   (acc),
    .inv_i   (inv_q),
    .valid_o (result_valid_o),
    .value_o (value),
    .seg_o   (segment_used_o),
    .sat_o   (saturated_o)
  );

  assign value_x_o = value[0];
  assign value_y_o = value[1];
  assign value_z_o = value[2];

endmodule

`default_nettype wire

// ===== sv/cbte_time.sv =====
// time front end: request decode, clamp to window, scale by inverse interval,
// segment index and fraction; three register stages. uses cbte_pkg
`default_nettype none

module cbte_time #(
  parameter int unsigned MaxPoints = cbte_pkg::MaxPointsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_i,
  input  wire logic [2:0]                    mode_i,
  input  wire logic [cbte_pkg::SegW-1:0]     point_index_i,
  input  wire logic [cbte_pkg::PointW-1:0]   point_i,
  input  wire logic [cbte_pkg::TimeW-1:0]    query_time_i,
  input  wire logic [cbte_pkg::TimeW-1:0]    start_time_i,
  input  wire logic [cbte_pkg::TimeW-1:0]    end_time_i,
  input  wire logic [31:0]                   inv_interval_i,
  input  wire logic [cbte_pkg::SegW-1:0]     seg_count_i,
  output cbte_pkg::ctl_t                     ctl_o,
  output cbte_pkg::wr_t                      wr_o,
  output logic [cbte_pkg::SegW-1:0]          seg_o,
  output logic [cbte_pkg::UW-1:0]            u_o
);

  localparam int unsigned Slots  = cbte_pkg::slots(MaxPoints);
  localparam int unsigned MaxSeg = Slots - 3;

  cbte_pkg::ctl_t ctl_d, ctl1_q, ctl2_q, ctl3_q;
  cbte_pkg::wr_t  wr_d, wr1_q, wr2_q, wr3_q;
  logic [cbte_pkg::TimeW-1:0] tc, d1_d, d1_q;
  logic [63:0]                x2_q;
  logic [cbte_pkg::SegW-1:0]  cnt, seg_d, seg3_q;
  logic [cbte_pkg::UW-1:0]    u_d, u3_q;
  logic                       idx_ok;

  always_comb begin
    idx_ok  = {1'b0, point_index_i} < 7'(Slots);
    ctl_d   = '0;
    wr_d    = '0;
    wr_d.idx = point_index_i;
    wr_d.pt  = point_i;
    if (req_i) begin
      case (cbte_pkg::mode_e'(mode_i))
        cbte_pkg::ModeWrPos: begin
          wr_d.en = idx_ok;
        end
        cbte_pkg::ModeWrRot: begin
          wr_d.en  = idx_ok;
          wr_d.tab = 1'b1;
        end
        cbte_pkg::ModePos: begin
          ctl_d.valid = 1'b1;
          ctl_d.kind  = cbte_pkg::KindPos;
        end
        cbte_pkg::ModeVel: begin
          ctl_d.valid = 1'b1;
          ctl_d.kind  = cbte_pkg::KindVel;
        end
        cbte_pkg::ModeAcc: begin
          ctl_d.valid = 1'b1;
          ctl_d.kind  = cbte_pkg::KindAcc;
        end
        cbte_pkg::ModeRotVec: begin
          ctl_d.valid = 1'b1;
          ctl_d.tab   = 1'b1;
          ctl_d.kind  = cbte_pkg::KindPos;
        end
        cbte_pkg::ModeRotRate: begin
          ctl_d.valid = 1'b1;
          ctl_d.tab   = 1'b1;
          ctl_d.kind  = cbte_pkg::KindVel;
        end
        default: begin
        end
      endcase
    end
    // clamp to [start, end]; empty window gives zero offset
    tc   = (query_time_i < end_time_i) ? query_time_i : end_time_i;
    d1_d = ((query_time_i > start_time_i) && (tc > start_time_i)) ?
           (tc - start_time_i) : '0;
  end

  always_comb begin
    if (seg_count_i == '0) begin
      cnt = 6'd1;
    end else if ({1'b0, seg_count_i} > 7'(MaxSeg)) begin
      cnt = 6'(MaxSeg);
    end else begin
      cnt = seg_count_i;
    end
    // past the last segment: last segment at u = 1
    if (x2_q[63:16] >= {42'b0, cnt}) begin
      seg_d = cnt - 6'd1;
      u_d   = cbte_pkg::UOne;
    end else begin
      seg_d = x2_q[21:16];
      u_d   = {1'b0, x2_q[15:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      wr1_q  <= '0;
      wr2_q  <= '0;
      wr3_q  <= '0;
    end else begin
      ctl1_q <= ctl_d;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      wr1_q  <= wr_d;
      wr2_q  <= wr1_q;
      wr3_q  <= wr2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q   <= d1_d;
    x2_q   <= 64'(d1_q) * 64'(inv_interval_i);
    seg3_q <= seg_d;
    u3_q   <= u_d;
  end

  assign ctl_o = ctl3_q;
  assign wr_o  = wr3_q;
  assign seg_o = seg3_q;
  assign u_o   = u3_q;

endmodule

`default_nettype wire

// ===== sv/cbte_mem.sv =====
// control point store: four banks by index mod 4, so the four points of a
// segment are read together; both tables share the banks. uses cbte_pkg
`default_nettype none

module cbte_mem #(
  parameter int unsigned MaxPoints = cbte_pkg::MaxPointsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cbte_pkg::ctl_t                ctl_i,
  input  wire cbte_pkg::wr_t                 wr_i,
  input  wire logic [cbte_pkg::SegW-1:0]     seg_i,
  input  wire logic [cbte_pkg::UW-1:0]       u_i,
  output cbte_pkg::ctl_t                     ctl_o,
  output logic [cbte_pkg::SegW-1:0]          seg_o,
  output logic [cbte_pkg::UW-1:0]            u_o,
  output logic [cbte_pkg::PointW-1:0]        rd_o [4],
  output logic [3:0]                         rd_vld_o
);

  localparam int unsigned Slots = cbte_pkg::slots(MaxPoints);
  localparam int unsigned Rows  = (Slots + 3) / 4;
  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;

  cbte_pkg::ctl_t            ctl_q;
  logic [cbte_pkg::SegW-1:0] seg_q;
  logic [cbte_pkg::UW-1:0]   u_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [cbte_pkg::PointW-1:0] mem [2][Rows];
    logic [Rows-1:0]             vld_q [2];
    logic [cbte_pkg::PointW-1:0] rd_q;
    logic                        rd_vld_q;
    logic [1:0]                  off;
    logic [6:0]                  pnt;
    logic [RowW-1:0]             rd_row, wr_row;
    logic                        wr_hit;

    always_comb begin
      // the one point of seg..seg+3 that lives in this bank
      off    = 2'(b) - seg_i[1:0];
      pnt    = {1'b0, seg_i} + {5'b0, off};
      rd_row = pnt[RowW+1:2];
      wr_row = wr_i.idx[RowW+1:2];
      wr_hit = wr_i.en && (wr_i.idx[1:0] == 2'(b));
    end

    always_ff @(posedge clk_i) begin
      if (wr_hit) begin
        mem[wr_i.tab][wr_row] <= wr_i.pt;
      end
      rd_q <= mem[ctl_i.tab][rd_row];
    end

    // unwritten slots read as zero
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[0] <= '0;
        vld_q[1] <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        if (wr_hit) begin
          vld_q[wr_i.tab][wr_row] <= 1'b1;
        end
        rd_vld_q <= vld_q[ctl_i.tab][rd_row];
      end
    end

    assign rd_o[b]     = rd_q;
    assign rd_vld_o[b] = rd_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_i;
    u_q   <= u_i;
  end

  assign ctl_o = ctl_q;
  assign seg_o = seg_q;
  assign u_o   = u_q;

endmodule

`default_nettype wire

// ===== sv/cbte_blend.sv =====
// basis blend: orders the four bank outputs, forms the point combinations and
// runs three horner steps (multiply stage, round-and-add stage). uses cbte_pkg
`default_nettype none

module cbte_blend (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cbte_pkg::ctl_t                ctl_i,
  input  wire logic [cbte_pkg::SegW-1:0]     seg_i,
  input  wire logic [cbte_pkg::UW-1:0]       u_i,
  input  wire logic [cbte_pkg::PointW-1:0]   rd_i [4],
  input  wire logic [3:0]                    rd_vld_i,
  output cbte_pkg::ctl_t                     ctl_o,
  output logic [cbte_pkg::SegW-1:0]          seg_o,
  output logic signed [cbte_pkg::AccW-1:0]  acc_o [3]
);

  localparam int unsigned AccW  = cbte_pkg::AccW;
  localparam int unsigned ProdW = AccW + cbte_pkg::UW + 1;

  cbte_pkg::ctl_t            s_ctl [4];
  logic [cbte_pkg::SegW-1:0] s_seg [4];
  logic signed [AccW-1:0]    s_acc [4][3];
  logic signed [AccW-1:0]    s_add [4][3][3];
  logic [cbte_pkg::UW-1:0]   s_u   [4][3];

  logic signed [AccW-1:0]    p [4][3];
  logic signed [AccW-1:0]    k3 [3], k2 [3], d20 [3], c0 [3];
  logic signed [AccW-1:0]    add_d [3][3];
  logic [cbte_pkg::UW-1:0]   u_d [3];

  always_comb begin
    logic [1:0] bsel;
    for (int k = 0; k < 4; k++) begin
      bsel = seg_i[1:0] + 2'(k);
      for (int a = 0; a < 3; a++) begin
        p[k][a] = rd_vld_i[bsel] ?
                  AccW'($signed(rd_i[bsel][a*cbte_pkg::CoordW +: cbte_pkg::CoordW])) : '0;
      end
    end
    for (int a = 0; a < 3; a++) begin
      k3[a]  = p[3][a] - p[0][a] + 3 * (p[1][a] - p[2][a]);
      k2[a]  = p[0][a] + p[2][a] - 2 * p[1][a];
      d20[a] = p[2][a] - p[0][a];
      c0[a]  = p[0][a] + p[2][a] + 4 * p[1][a];
    end
    // a step with u = 1 passes the sum through unchanged
    for (int a = 0; a < 3; a++) begin
      case (ctl_i.kind)
        cbte_pkg::KindPos: begin
          add_d[0][a] = 3 * k2[a];
          add_d[1][a] = 3 * d20[a];
          add_d[2][a] = c0[a];
        end
        cbte_pkg::KindVel: begin
          add_d[0][a] = 2 * k2[a];
          add_d[1][a] = d20[a];
          add_d[2][a] = '0;
        end
        default: begin
          add_d[0][a] = k2[a];
          add_d[1][a] = '0;
          add_d[2][a] = '0;
        end
      endcase
    end
    case (ctl_i.kind)
      cbte_pkg::KindPos: begin
        u_d[0] = u_i;
        u_d[1] = u_i;
        u_d[2] = u_i;
      end
      cbte_pkg::KindVel: begin
        u_d[0] = u_i;
        u_d[1] = u_i;
        u_d[2] = cbte_pkg::UOne;
      end
      default: begin
        u_d[0] = u_i;
        u_d[1] = cbte_pkg::UOne;
        u_d[2] = cbte_pkg::UOne;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_ctl[0] <= '0;
    end else begin
      s_ctl[0] <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_seg[0] <= seg_i;
    s_acc[0] <= k3;
    s_add[0] <= add_d;
    s_u[0]   <= u_d;
  end

  for (genvar j = 0; j < 3; j++) begin : g_step
    cbte_pkg::ctl_t            m_ctl;
    logic [cbte_pkg::SegW-1:0] m_seg;
    logic signed [ProdW-1:0]   m_prod [3];
    logic signed [AccW-1:0]    m_add  [3][3];
    logic [cbte_pkg::UW-1:0]   m_u    [3];
    logic [ProdW-1:0]          rsum   [3];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_ctl        <= '0;
        s_ctl[j+1]   <= '0;
      end else begin
        m_ctl        <= s_ctl[j];
        s_ctl[j+1]   <= m_ctl;
      end
    end

    // round half away from zero: bias 2^15, one less when negative
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        rsum[a] = m_prod[a] + ProdW'(32767) + ProdW'(~m_prod[a][ProdW-1]);
      end
    end

    always_ff @(posedge clk_i) begin
      for (int a = 0; a < 3; a++) begin
        m_prod[a]     <= s_acc[j][a] * $signed({1'b0, s_u[j][j]});
        s_acc[j+1][a] <= rsum[a][AccW+15:16] + m_add[j][a];
      end
      m_seg      <= s_seg[j];
      m_add      <= s_add[j];
      m_u        <= s_u[j];
      s_seg[j+1] <= m_seg;
      s_add[j+1] <= m_add;
      s_u[j+1]   <= m_u;
    end
  end

  assign ctl_o = s_ctl[3];
  assign seg_o = s_seg[3];
  assign acc_o = s_acc[3];

endmodule

`default_nettype wire

// ===== sv/cbte_post.sv =====
// output scaling: divide by six for values, one or two products with the
// inverse interval for derivatives, 48 bit clamps and int32 clip. uses cbte_pkg
`default_nettype none

module cbte_post (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cbte_pkg::ctl_t                ctl_i,
  input  wire logic [cbte_pkg::SegW-1:0]     seg_i,
  input  wire logic signed [cbte_pkg::AccW-1:0] acc_i [3],
  input  wire logic [31:0]                   inv_i,
  output logic                               valid_o,
  output logic [cbte_pkg::CoordW-1:0]        value_o [3],
  output logic [cbte_pkg::SegW-1:0]          seg_o,
  output logic                               sat_o
);

  localparam int unsigned AccW = cbte_pkg::AccW;
  localparam int unsigned MagW = cbte_pkg::MagW;

  cbte_pkg::ctl_t            a_ctl, b_ctl, c_ctl, d_ctl, e_ctl;
  logic [cbte_pkg::SegW-1:0] a_seg, b_seg, c_seg, d_seg, e_seg, f_seg;
  logic                      a_neg [3], b_neg [3], c_neg [3], d_neg [3], e_neg [3];
  logic                      a_big [3], b_big [3], c_big [3], d_big [3], e_big [3];
  logic [AccW-1:0]           a_mag [3];
  logic [33:0]               a_n   [3];
  logic [51:0]               b_ph  [3], b_pl [3];
  logic [63:0]               b_lo  [3], d_lo [3];
  logic [39:0]               b_hi  [3];
  logic [47:0]               d_hi  [3];
  logic [32:0]               c_q   [3], d_q [3], e_q [3];
  logic [MagW-1:0]           c_r1  [3], d_r1 [3], e_r1 [3], e_r2 [3];
  logic                      f_valid, f_sat;
  logic [cbte_pkg::CoordW-1:0] f_val [3];

  logic [AccW:0]   t      [3];
  logic [68:0]     sumq   [3];
  logic [71:0]     sum1   [3];
  logic [55:0]     r1w    [3];
  logic [79:0]     sum2   [3];
  logic [63:0]     r2w    [3];
  logic [MagW-1:0] m      [3];
  logic [cbte_pkg::CoordW-1:0] val_d [3];
  logic            clip   [3];

  // magnitude plus three, halved when registered, for the rounded divide by six
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      t[a] = acc_i[a][AccW-1] ? ({1'b0, ~acc_i[a]} + (AccW+1)'(4)) :
                                ({1'b0, acc_i[a]}  + (AccW+1)'(3));
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sumq[a] = {b_ph[a], 17'b0} + 69'(b_pl[a]);
      sum1[a] = {b_hi[a], 32'b0} + 72'(b_lo[a]) +
                ((c_ctl_kind_vel(b_ctl)) ? 72'h1_0000 : 72'h8000);
      r1w[a]  = c_ctl_kind_vel(b_ctl) ? 56'(sum1[a][71:17]) : sum1[a][71:16];
      sum2[a] = {d_hi[a], 32'b0} + 80'(d_lo[a]) + 80'h8000;
      r2w[a]  = sum2[a][79:16];
    end
  end

  function automatic logic c_ctl_kind_vel(cbte_pkg::ctl_t c);
    return c.kind == cbte_pkg::KindVel;
  endfunction

  always_comb begin
    f_sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      case (e_ctl.kind)
        cbte_pkg::KindPos: m[a] = e_big[a] ? cbte_pkg::Lim48 : MagW'(e_q[a]);
        cbte_pkg::KindVel: m[a] = e_r1[a];
        cbte_pkg::KindAcc: m[a] = e_r2[a];
        default:           m[a] = '0;
      endcase
      if (!e_neg[a]) begin
        clip[a]  = m[a] > 48'h0000_7FFF_FFFF;
        val_d[a] = clip[a] ? 32'h7FFF_FFFF : m[a][31:0];
      end else begin
        clip[a]  = m[a] > 48'h0000_8000_0000;
        val_d[a] = clip[a] ? 32'h8000_0000 : (32'd0 - m[a][31:0]);
      end
      f_sat = f_sat | clip[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl   <= '0;
      b_ctl   <= '0;
      c_ctl   <= '0;
      d_ctl   <= '0;
      e_ctl   <= '0;
      f_valid <= 1'b0;
    end else begin
      a_ctl   <= ctl_i;
      b_ctl   <= a_ctl;
      c_ctl   <= b_ctl;
      d_ctl   <= c_ctl;
      e_ctl   <= d_ctl;
      f_valid <= e_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    a_seg <= seg_i;
    b_seg <= a_seg;
    c_seg <= b_seg;
    d_seg <= c_seg;
    e_seg <= d_seg;
    f_seg <= e_seg;
    for (int a = 0; a < 3; a++) begin
      a_neg[a] <= acc_i[a][AccW-1];
      a_mag[a] <= acc_i[a][AccW-1] ? AccW'(-acc_i[a]) : AccW'(acc_i[a]);
      a_n[a]   <= t[a][34:1];
      a_big[a] <= |t[a][AccW:35];

      b_neg[a] <= a_neg[a];
      b_big[a] <= a_big[a];
      b_ph[a]  <= 52'(a_n[a][33:17]) * 52'(cbte_pkg::Div3Mul);
      b_pl[a]  <= 52'(a_n[a][16:0]) * 52'(cbte_pkg::Div3Mul);
      b_lo[a]  <= 64'(a_mag[a][31:0]) * 64'(inv_i);
      b_hi[a]  <= 40'(a_mag[a][39:32]) * 40'(inv_i);

      c_neg[a] <= b_neg[a];
      c_big[a] <= b_big[a];
      c_q[a]   <= sumq[a][68:36];
      c_r1[a]  <= (|r1w[a][55:48]) ? cbte_pkg::Lim48 : r1w[a][47:0];

      d_neg[a] <= c_neg[a];
      d_big[a] <= c_big[a];
      d_q[a]   <= c_q[a];
      d_r1[a]  <= c_r1[a];
      d_lo[a]  <= 64'(c_r1[a][31:0]) * 64'(inv_i);
      d_hi[a]  <= 48'(c_r1[a][47:32]) * 48'(inv_i);

      e_neg[a] <= d_neg[a];
      e_big[a] <= d_big[a];
      e_q[a]   <= d_q[a];
      e_r1[a]  <= d_r1[a];
      e_r2[a]  <= (|r2w[a][63:48]) ? cbte_pkg::Lim48 : r2w[a][47:0];

      f_val[a] <= val_d[a];
    end
    sat_o <= f_sat;
  end

  assign valid_o = f_valid;
  assign value_o = f_val;
  assign seg_o   = f_seg;

endmodule

`default_nettype wire
